// ===== hw/rtl/tqub_pkg.sv =====
// Shared types and constants for the tile quadrant upsample and blur block.
// Holds the opcode, register index and sequencer state codes and the config struct.
// No dependencies.
package tqub_pkg;

	localparam int SampleBits = 8;
	localparam int TileSide = 64;
	localparam int SideBits = 6;
	localparam int Channels = 3;
	localparam int AddrBits = 14;
	localparam int StoreDepth = TileSide * TileSide * Channels;
	localparam int SumBits = 12;
	localparam logic [3:0] WeightMax = 4'd10;
	localparam logic [SideBits-1:0] LastInner = SideBits'(TileSide - 2);
	localparam logic [SideBits-1:0] LastPos = SideBits'(TileSide - 1);
	localparam logic [1:0] LastChannel = 2'(Channels - 1);

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_PROCESS = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_RIGHT = 2'd0,
		REG_BOTTOM = 2'd1,
		REG_NEAREST = 2'd2,
		REG_STRENGTH = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_CP_RD,
		ST_CP_WR,
		ST_L0,
		ST_L1,
		ST_L2,
		ST_LN,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic right_half;
		logic bottom_half;
		logic nearest_only;
		logic [3:0] blur_strength;
	} cfg_t;

endpackage

// ===== hw/rtl/tqub_cfg.sv =====
// Configuration registers behind the APB-style port.
// Depends on tqub_pkg for the register index codes and the config struct.
module tqub_cfg
	import tqub_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;
	reg_idx_t idx;

	assign idx = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_RIGHT: cfg_q.right_half <= pwdata[0];
				REG_BOTTOM: cfg_q.bottom_half <= pwdata[0];
				REG_NEAREST: cfg_q.nearest_only <= pwdata[0];
				REG_STRENGTH: cfg_q.blur_strength <= pwdata[3:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RIGHT: prdata = {31'd0, cfg_q.right_half};
			REG_BOTTOM: prdata = {31'd0, cfg_q.bottom_half};
			REG_NEAREST: prdata = {31'd0, cfg_q.nearest_only};
			REG_STRENGTH: prdata = {28'd0, cfg_q.blur_strength};
			default: prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/tqub_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on tqub_pkg for the dividend width.
module tqub_div
	import tqub_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SumBits-1:0] dividend,
	input  logic [3:0]         divisor,
	output logic               done,
	output logic [SumBits-1:0] quotient
);

	logic [SumBits-1:0] num_q;
	logic [3:0] den_q;
	logic [3:0] rem_q;
	logic [3:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [4:0] trial;
	logic fits;

	assign trial = {rem_q, num_q[SumBits-1]};
	assign fits = trial >= {1'b0, den_q};
	assign done = done_q;
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(SumBits - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[SumBits-2:0], fits};
			rem_q <= fits ? 4'(trial - {1'b0, den_q}) : trial[3:0];
		end
	end

endmodule

// ===== hw/rtl/tile_quadrant_upsample_blur.sv =====
// Top level: sample stores, process sequencer and the result strobe.
// Depends on tqub_pkg, tqub_cfg and tqub_div.
//
// A load request is written into the source store on acceptance; a read
// request's result appears on the cycle after acceptance; a process request
// walks the whole tile: the CP_RD and CP_WR states per sample for the quadrant
// copy, then, unless nearest_only is set, the L0, L1 and L2 states prime the
// window per line and the LN and DIV states run the shared divider per inner
// sample for each of the row and column passes. The result strobe lasts one
// cycle and cannot be held off by the receiver.
module tile_quadrant_upsample_blur
	import tqub_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            op,
	input  logic [SideBits-1:0]   row,
	input  logic [SideBits-1:0]   column,
	input  logic [1:0]            channel,
	input  logic [SampleBits-1:0] sample_in,
	output logic                  result_valid,
	output logic [SampleBits-1:0] sample_out,
	output logic                  done_res
);

	cfg_t cfg;
	state_t state_q, state_d;

	logic [SampleBits-1:0] src_mem [0:StoreDepth-1];
	logic [SampleBits-1:0] res_mem [0:StoreDepth-1];
	logic [SampleBits-1:0] src_rdata_q, res_rdata_q;
	logic [AddrBits-1:0] src_raddr, res_raddr, res_waddr;
	logic res_we;
	logic [SampleBits-1:0] res_wdata;

	logic pass_q;
	logic [1:0] ch_q;
	logic [SideBits-1:0] ln_q, idx_q;
	logic [SampleBits-1:0] prev_q, cur_q;
	logic inside_q;

	logic accept;
	op_t op_in;
	logic [3:0] strength, weight;
	logic div_start, div_done;
	logic [SumBits-1:0] div_num, div_quo;
	logic [SideBits-1:0] rd_k;

	function automatic logic [AddrBits-1:0] line_addr(input logic pass, input logic [1:0] ch,
			input logic [SideBits-1:0] ln, input logic [SideBits-1:0] k);
		line_addr = pass ? {ch, k, ln} : {ch, ln, k};
	endfunction

	tqub_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	assign strength = (cfg.blur_strength > WeightMax) ? WeightMax : cfg.blur_strength;
	assign weight = WeightMax - strength;
	assign div_num = SumBits'(cur_q * weight) + SumBits'(prev_q) + SumBits'(res_rdata_q);

	tqub_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(weight + 4'd2), .done(div_done), .quotient(div_quo)
	);

	assign op_in = op_t'(op);
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept && op_in == OP_LOAD && channel <= LastChannel) begin
			src_mem[{channel, row, column}] <= sample_in;
		end
		src_rdata_q <= src_mem[src_raddr];
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_mem[res_waddr] <= res_wdata;
		end
		res_rdata_q <= res_mem[res_raddr];
	end

	assign src_raddr = {ch_q, cfg.bottom_half, ln_q[SideBits-1:1],
		cfg.right_half, idx_q[SideBits-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q <= 1'b0;
			ch_q <= '0;
			ln_q <= '0;
			idx_q <= '0;
			inside_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					inside_q <= (channel <= LastChannel);
					pass_q <= 1'b0;
					ch_q <= '0;
					ln_q <= '0;
					idx_q <= '0;
				end
				ST_CP_WR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LastPos) begin
						ln_q <= ln_q + 1'b1;
						if (ln_q == LastPos) begin
							ch_q <= (ch_q == LastChannel) ? 2'd0 : ch_q + 2'd1;
						end
					end
				end
				ST_L2: idx_q <= 6'd1;
				ST_DIV: begin
					if (div_done) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == LastInner) begin
							ln_q <= ln_q + 1'b1;
							if (ln_q == LastPos) begin
								if (ch_q == LastChannel) begin
									ch_q <= '0;
									pass_q <= 1'b1;
								end else begin
									ch_q <= ch_q + 2'd1;
								end
							end
						end
					end
				end
				default: pass_q <= pass_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_L1: prev_q <= res_rdata_q;
			ST_L2: cur_q <= res_rdata_q;
			ST_LN: begin
				prev_q <= cur_q;
				cur_q <= res_rdata_q;
			end
			default: cur_q <= cur_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		res_we = 1'b0;
		res_waddr = {ch_q, ln_q, idx_q};
		res_wdata = src_rdata_q;
		res_raddr = line_addr(pass_q, ch_q, ln_q, idx_q);
		rd_k = '0;
		div_start = 1'b0;
		result_valid = 1'b0;
		sample_out = '0;
		done_res = 1'b0;
		case (state_q)
			ST_IDLE: begin
				res_raddr = {(channel <= LastChannel) ? channel : 2'd0, row, column};
				if (accept && op_in == OP_READ) begin
					state_d = ST_READ;
				end else if (accept && op_in == OP_PROCESS) begin
					state_d = ST_CP_RD;
				end
			end
			ST_READ: begin
				result_valid = 1'b1;
				sample_out = inside_q ? res_rdata_q : '0;
				state_d = ST_IDLE;
			end
			ST_CP_RD: state_d = ST_CP_WR;
			ST_CP_WR: begin
				res_we = 1'b1;
				if (idx_q == LastPos && ln_q == LastPos && ch_q == LastChannel) begin
					state_d = cfg.nearest_only ? ST_DONE : ST_L0;
				end else begin
					state_d = ST_CP_RD;
				end
			end
			ST_L0: begin
				res_raddr = line_addr(pass_q, ch_q, ln_q, 6'd0);
				state_d = ST_L1;
			end
			ST_L1: begin
				res_raddr = line_addr(pass_q, ch_q, ln_q, 6'd1);
				state_d = ST_L2;
			end
			ST_L2: begin
				res_raddr = line_addr(pass_q, ch_q, ln_q, 6'd2);
				state_d = ST_LN;
			end
			ST_LN: begin
				div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				rd_k = idx_q + 6'd2;
				res_raddr = line_addr(pass_q, ch_q, ln_q, rd_k);
				res_waddr = line_addr(pass_q, ch_q, ln_q, idx_q);
				res_wdata = div_quo[SampleBits-1:0];
				if (div_done) begin
					res_we = 1'b1;
					if (idx_q == LastInner) begin
						if (ln_q == LastPos && ch_q == LastChannel && pass_q) begin
							state_d = ST_DONE;
						end else begin
							state_d = ST_L0;
						end
					end else begin
						state_d = ST_LN;
					end
				end
			end
			ST_DONE: begin
				result_valid = 1'b1;
				done_res = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== tb/tb.sv =====
// Testbench for tile_quadrant_upsample_blur: loads, processes and reads are
// checked against a behavioral upsample and blur model kept in this file.
// Depends on tqub_pkg and the tile_quadrant_upsample_blur RTL.
module tb;
	import tqub_pkg::*;

	typedef struct {
		op_t             op;
		logic [5:0]      row;
		logic [5:0]      column;
		logic [1:0]      channel;
		logic [7:0]      sample;
	} request_t;

	typedef struct {
		logic [7:0] sample;
		logic       done;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [1:0] op = '0;
	logic [5:0] row = '0, column = '0;
	logic [1:0] channel = '0;
	logic [7:0] sample_in = '0;
	logic result_valid;
	logic [7:0] sample_out;
	logic done_res;

	request_t pending_requests[$];
	answer_t  expected_answers[$];
	int       gap_pct = 0;
	int       error_count = 0;

	logic [7:0] source_tile[StoreDepth];
	logic [7:0] result_tile[StoreDepth];
	cfg_t       cfg_model = '0;

	tile_quadrant_upsample_blur i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int tile_index(int r, int c, int ch);
		return r * TileSide * Channels + c * Channels + ch;
	endfunction

	function automatic void blur_pass(int base, int stride, int weight);
		logic [7:0] line[TileSide];
		for (int i = 0; i < TileSide; i++)
			line[i] = result_tile[base + i * stride];
		for (int i = 1; i < TileSide - 1; i++)
			result_tile[base + i * stride] = 8'((int'(line[i]) * weight
				+ int'(line[i - 1]) + int'(line[i + 1])) / (weight + 2));
	endfunction

	function automatic void run_upsample();
		int r0;
		int c0;
		int weight;
		r0 = cfg_model.bottom_half ? TileSide / 2 : 0;
		c0 = cfg_model.right_half ? TileSide / 2 : 0;
		weight = 10 - (cfg_model.blur_strength > 10 ? 10 : int'(cfg_model.blur_strength));
		for (int y = 0; y < TileSide; y++)
			for (int x = 0; x < TileSide; x++)
				for (int ch = 0; ch < Channels; ch++)
					result_tile[tile_index(y, x, ch)] =
						source_tile[tile_index(r0 + y / 2, c0 + x / 2, ch)];
		if (!cfg_model.nearest_only) begin
			for (int ch = 0; ch < Channels; ch++)
				for (int y = 0; y < TileSide; y++)
					blur_pass(tile_index(y, 0, ch), Channels, weight);
			for (int ch = 0; ch < Channels; ch++)
				for (int x = 0; x < TileSide; x++)
					blur_pass(tile_index(0, x, ch), TileSide * Channels, weight);
		end
	endfunction

	function automatic void predict_request(request_t rq);
		answer_t a;
		case (rq.op)
			OP_LOAD: begin
				if (rq.channel < Channels)
					source_tile[tile_index(rq.row, rq.column, rq.channel)] = rq.sample;
			end
			OP_PROCESS: begin
				run_upsample();
				a.sample = '0;
				a.done = 1'b1;
				expected_answers = {expected_answers, a};
			end
			OP_READ: begin
				a.sample = rq.channel < Channels ?
					result_tile[tile_index(rq.row, rq.column, rq.channel)] : '0;
				a.done = 1'b0;
				expected_answers = {expected_answers, a};
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		request_t rq;
		if (start && !busy) begin
			rq.op = op_t'(op);
			rq.row = row;
			rq.column = column;
			rq.channel = channel;
			rq.sample = sample_in;
			predict_request(rq);
		end
		if (!start || !busy) begin
			if (pending_requests.size() > 0 && $urandom_range(99) >= gap_pct) begin
				rq = pending_requests.pop_front();
				start <= 1'b1;
				op <= rq.op;
				row <= rq.row;
				column <= rq.column;
				channel <= rq.channel;
				sample_in <= rq.sample;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	always @(posedge clk) begin
		answer_t a;
		if (result_valid) begin
			if (expected_answers.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				a = expected_answers.pop_front();
				if (sample_out !== a.sample)
					report_mismatch("sample_out", sample_out, a.sample);
				if (done_res !== a.done)
					report_mismatch("done_res", done_res, a.done);
			end
		end
	end

	task automatic queue_request(op_t o, int r, int c, int ch, int v);
		request_t rq;
		rq.op = o;
		rq.row = 6'(r);
		rq.column = 6'(c);
		rq.channel = 2'(ch);
		rq.sample = 8'(v);
		pending_requests = {pending_requests, rq};
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_requests.size() > 0 || start || expected_answers.size() > 0 || busy);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(4 * int'(idx));
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RIGHT: cfg_model.right_half = value[0];
			REG_BOTTOM: cfg_model.bottom_half = value[0];
			REG_NEAREST: cfg_model.nearest_only = value[0];
			default: cfg_model.blur_strength = 4'(value);
		endcase
	endtask

	task automatic configure(int rh, int bh, int nn, int s);
		write_reg(REG_RIGHT, rh);
		write_reg(REG_BOTTOM, bh);
		write_reg(REG_NEAREST, nn);
		write_reg(REG_STRENGTH, s);
	endtask

	task automatic queue_random_request();
		int pick;
		pick = $urandom_range(99);
		if (pick < 45)
			queue_request(OP_LOAD, $urandom_range(63), $urandom_range(63),
				$urandom_range(3), $urandom_range(255));
		else if (pick < 95)
			queue_request(OP_READ, $urandom_range(63), $urandom_range(63),
				$urandom_range(3), $urandom_range(255));
		else
			queue_request(OP_NONE, $urandom_range(63), $urandom_range(63),
				$urandom_range(3), $urandom_range(255));
	endtask

	initial begin
		int gaps[4] = '{0, 65, 65, 32};
		int spot;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		configure(0, 0, 1, 0);
		for (int r = 0; r < TileSide; r++)
			for (int c = 0; c < TileSide; c++)
				for (int ch = 0; ch < Channels; ch++)
					queue_request(OP_LOAD, r, c, ch, $urandom_range(255));
		queue_request(OP_LOAD, 0, 0, 0, 255);
		queue_request(OP_LOAD, 63, 63, 2, 0);
		queue_request(OP_LOAD, 5, 5, 3, 77);
		queue_request(OP_NONE, 63, 63, 3, 255);
		queue_request(OP_PROCESS, 0, 0, 0, 0);
		queue_request(OP_READ, 0, 0, 0, 0);
		queue_request(OP_READ, 63, 63, 2, 0);
		queue_request(OP_READ, 0, 63, 1, 0);
		queue_request(OP_READ, 63, 0, 2, 0);
		queue_request(OP_READ, 10, 10, 3, 0);
		drain();
		configure(1, 0, 0, 0);
		queue_request(OP_PROCESS, 0, 0, 0, 0);
		queue_request(OP_READ, 0, 0, 0, 0);
		queue_request(OP_READ, 1, 1, 1, 0);
		queue_request(OP_READ, 31, 32, 2, 0);
		queue_request(OP_READ, 62, 62, 0, 0);
		drain();
		configure(1, 1, 0, 15);
		queue_request(OP_PROCESS, 0, 0, 0, 0);
		queue_request(OP_READ, 1, 1, 0, 0);
		queue_request(OP_READ, 63, 62, 1, 0);
		queue_request(OP_READ, 32, 0, 2, 0);
		drain();
		foreach (gaps[p]) begin
			gap_pct = gaps[p];
			configure($urandom_range(1), $urandom_range(1), 1, $urandom_range(15));
			spot = $urandom_range(380);
			for (int i = 0; i < 390; i++) begin
				if (i == spot)
					queue_request(OP_PROCESS, 0, 0, 0, 0);
				queue_random_request();
			end
			drain();
		end
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#50000000;
		$display("FAILURE");
		$finish;
	end
endmodule
